// ----- rtl/lcc_pkg.sv -----
// shared types and constants for the luhn card number checker
package lcc_pkg;

	localparam int SYM_W   = 8;
	localparam int CNT_W   = 6;
	localparam int SUM_W   = 4;
	localparam int STAT_W  = 3;
	localparam int DIGIT_W = 4;
	localparam int CFG_W   = 6;
	localparam int OUT_W   = 16;

	localparam logic [CNT_W-1:0] CNT_MAX        = 6'd63;
	localparam logic [CNT_W-1:0] MIN_DIGITS_RST = 6'd13;
	localparam logic [CNT_W-1:0] MAX_DIGITS_RST = 6'd19;

	localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;
	localparam logic [SYM_W-1:0] CH_NINE  = 8'h39;
	localparam logic [SYM_W-1:0] CH_SPACE = 8'h20;
	localparam logic [SYM_W-1:0] CH_DASH  = 8'h2d;

	// character classes
	localparam logic [1:0] KIND_NONE  = 2'd0;
	localparam logic [1:0] KIND_DIGIT = 2'd1;
	localparam logic [1:0] KIND_SKIP  = 2'd2;
	localparam logic [1:0] KIND_BAD   = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
	localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd1;
	localparam logic [STAT_W-1:0] ST_BADCHAR = 3'd2;
	localparam logic [STAT_W-1:0] ST_BADLEN  = 3'd3;
	localparam logic [STAT_W-1:0] ST_LUHN    = 3'd4;

	// config register indexes
	localparam logic REG_MIN_DIGITS = 1'b0;
	localparam logic REG_MAX_DIGITS = 1'b1;

	typedef struct packed {
		logic [1:0]         kind;
		logic [DIGIT_W-1:0] digit;
		logic               last;
	} cls_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] min_digits;
		logic [CNT_W-1:0] max_digits;
	} len_cfg_t;

endpackage

// ----- rtl/lcc_front.sv -----
// front end: classifies each item into none, digit, separator or bad
module lcc_front (
	input  logic [lcc_pkg::SYM_W-1:0] symbol,
	input  logic                      has_symbol,
	input  logic                      last,
	output logic                      push,
	output lcc_pkg::cls_item_t        item
);

	logic                        is_digit;
	logic [lcc_pkg::SYM_W-1:0]   offs;

	assign offs     = symbol - lcc_pkg::CH_ZERO;
	assign is_digit = (symbol >= lcc_pkg::CH_ZERO) && (symbol <= lcc_pkg::CH_NINE);

	always_comb begin
		item.last  = last;
		item.digit = offs[lcc_pkg::DIGIT_W-1:0];
		if (!has_symbol) begin
			item.kind = lcc_pkg::KIND_NONE;
		end else if (is_digit) begin
			item.kind = lcc_pkg::KIND_DIGIT;
		end else if (symbol == lcc_pkg::CH_SPACE || symbol == lcc_pkg::CH_DASH) begin
			item.kind = lcc_pkg::KIND_SKIP;
		end else begin
			item.kind = lcc_pkg::KIND_BAD;
		end
	end

	// a bare item that does not end the string changes nothing, drop it here
	assign push = has_symbol || last;

endmodule

// ----- rtl/lcc_fifo.sv -----
// short queue of classified items between front and back
module lcc_fifo #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  lcc_pkg::cls_item_t wr_item,
	output logic               full,
	input  logic               rd_en,
	output lcc_pkg::cls_item_t rd_item,
	output logic               empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	lcc_pkg::cls_item_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ----- rtl/lcc_back.sv -----
// back end: running luhn sums, digit count, verdict and output register
module lcc_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lcc_pkg::len_cfg_t           cfg,
	input  logic                        in_avail,
	input  lcc_pkg::cls_item_t          in_item,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [lcc_pkg::OUT_W-1:0]   m_tdata
);

	logic                         seen_any_q;
	logic                         bad_char_q;
	logic [lcc_pkg::CNT_W-1:0]    digits_q;
	logic [lcc_pkg::SUM_W-1:0]    sum_even_q;
	logic [lcc_pkg::SUM_W-1:0]    sum_odd_q;
	logic                         out_valid_q;
	logic [lcc_pkg::OUT_W-1:0]    out_data_q;

	logic                         take_digit;
	logic [lcc_pkg::SUM_W:0]      dbl_raw;
	logic [lcc_pkg::SUM_W-1:0]    dbl;
	logic [lcc_pkg::SUM_W-1:0]    add_even;
	logic [lcc_pkg::SUM_W-1:0]    add_odd;
	logic [lcc_pkg::SUM_W:0]      raw_even;
	logic [lcc_pkg::SUM_W:0]      raw_odd;
	logic                         seen_n;
	logic                         bad_n;
	logic [lcc_pkg::CNT_W-1:0]    digits_n;
	logic [lcc_pkg::SUM_W-1:0]    sum_even_n;
	logic [lcc_pkg::SUM_W-1:0]    sum_odd_n;
	logic [lcc_pkg::SUM_W-1:0]    pick;
	logic [lcc_pkg::STAT_W-1:0]   status;
	logic                         out_free;

	assign out_free = !out_valid_q || m_tready;
	// items without last never touch the output register
	assign pop      = in_avail && (!in_item.last || out_free);

	// per-digit update, doubled value folded by subtracting 9
	assign take_digit = (in_item.kind == lcc_pkg::KIND_DIGIT) && (digits_q != lcc_pkg::CNT_MAX);
	assign dbl_raw    = {in_item.digit, 1'b0};
	assign dbl        = (dbl_raw > 5'd9) ? lcc_pkg::SUM_W'(dbl_raw - 5'd9)
	                                     : dbl_raw[lcc_pkg::SUM_W-1:0];
	assign add_even   = digits_q[0] ? in_item.digit : dbl;
	assign add_odd    = digits_q[0] ? dbl : in_item.digit;
	assign raw_even   = {1'b0, sum_even_q} + {1'b0, add_even};
	assign raw_odd    = {1'b0, sum_odd_q} + {1'b0, add_odd};

	always_comb begin
		seen_n     = seen_any_q || (in_item.kind != lcc_pkg::KIND_NONE);
		bad_n      = bad_char_q || (in_item.kind == lcc_pkg::KIND_BAD);
		digits_n   = digits_q;
		sum_even_n = sum_even_q;
		sum_odd_n  = sum_odd_q;
		if (take_digit) begin
			digits_n   = digits_q + 1'b1;
			sum_even_n = (raw_even >= 5'd10) ? lcc_pkg::SUM_W'(raw_even - 5'd10)
			                                 : raw_even[lcc_pkg::SUM_W-1:0];
			sum_odd_n  = (raw_odd >= 5'd10) ? lcc_pkg::SUM_W'(raw_odd - 5'd10)
			                                : raw_odd[lcc_pkg::SUM_W-1:0];
		end
	end

	assign pick = digits_n[0] ? sum_odd_n : sum_even_n;

	always_comb begin
		if (!seen_n) begin
			status = lcc_pkg::ST_EMPTY;
		end else if (bad_n) begin
			status = lcc_pkg::ST_BADCHAR;
		end else if (digits_n < cfg.min_digits || digits_n > cfg.max_digits) begin
			status = lcc_pkg::ST_BADLEN;
		end else if (pick != '0) begin
			status = lcc_pkg::ST_LUHN;
		end else begin
			status = lcc_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_any_q  <= 1'b0;
			bad_char_q  <= 1'b0;
			digits_q    <= '0;
			sum_even_q  <= '0;
			sum_odd_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (in_item.last) begin
					seen_any_q  <= 1'b0;
					bad_char_q  <= 1'b0;
					digits_q    <= '0;
					sum_even_q  <= '0;
					sum_odd_q   <= '0;
					out_valid_q <= 1'b1;
				end else begin
					seen_any_q <= seen_n;
					bad_char_q <= bad_n;
					digits_q   <= digits_n;
					sum_even_q <= sum_even_n;
					sum_odd_q  <= sum_odd_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && in_item.last) begin
			out_data_q <= {6'd0, digits_n, status, (status == lcc_pkg::ST_OK)};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ----- rtl/luhn_card_number_check.sv -----
// luhn card number checker top level
//
// usage:
//   characters of a card number stream in on the s_ side, one item per cycle while s_tready is high
//   s_tdata carries the character byte, s_tuser says the byte is present,
//   s_tlast ends the string; spaces and dashes are skipped, digits counted
//   one result item leaves on the m_ side for each item with s_tlast set:
//   valid flag, status code and saturated digit count
//   throughput: one item per cycle sustained while results are taken, set by the
//   single add-mod-10 step of the back end
//   an accepted item is in the queue the next cycle, the back end reads it there
//   and registers the result in the output register; an item that ends a string
//   waits in the queue while the output register holds a result not yet taken
//   min and max length registers are written over the cfg port, by the user only
//   while idle, which the block does not enforce; reset clears the queue, the
//   per-string state and the output valid flag, and loads the length limits with 13 and 19
//   when the receiver stalls the result holds in the output register; items
//   that do not end a string keep draining until a string-ending item reaches
//   the head of the queue, which then fills; s_tready drops only once it is full
module luhn_card_number_check #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic        s_tuser,   // [0] has_symbol
	input  logic        s_tlast,   // last
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] valid_res, [3:1] status, [9:4] digit_count, rest zero
	// configuration writes
	input  logic        cfg_we,
	input  logic        cfg_addr,
	input  logic [5:0]  cfg_wdata
);

	lcc_pkg::len_cfg_t  cfg_q;
	lcc_pkg::cls_item_t front_item;
	lcc_pkg::cls_item_t queue_item;
	logic               front_push;
	logic               queue_full;
	logic               queue_empty;
	logic               back_pop;

	// length limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_digits <= lcc_pkg::MIN_DIGITS_RST;
			cfg_q.max_digits <= lcc_pkg::MAX_DIGITS_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				lcc_pkg::REG_MIN_DIGITS: cfg_q.min_digits <= cfg_wdata;
				lcc_pkg::REG_MAX_DIGITS: cfg_q.max_digits <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// classify each character as it arrives
	lcc_front u_front (
		.symbol     (s_tdata),
		.has_symbol (s_tuser),
		.last       (s_tlast),
		.push       (front_push),
		.item       (front_item)
	);

	// accept whenever the queue has room; dropped bare items still handshake
	assign s_tready = !queue_full;

	lcc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (s_tvalid && front_push),
		.wr_item (front_item),
		.full    (queue_full),
		.rd_en   (back_pop),
		.rd_item (queue_item),
		.empty   (queue_empty)
	);

	// running sums and verdict
	lcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_avail (!queue_empty),
		.in_item  (queue_item),
		.pop      (back_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule

// ----- sim/tb.sv -----
// testbench for the luhn card number checker, directed table then random card numbers
`timescale 1ns / 1ps

module tb;

	// expected result item, fields declared in the order of m_tdata from bit 0 up
	typedef struct packed {
		logic                       ok;
		logic [lcc_pkg::STAT_W-1:0] status;
		logic [lcc_pkg::CNT_W-1:0]  count;
	} card_verdict_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_op_t;

	// one stimulus step: either a character item or a register write
	typedef struct {
		row_op_t       op;
		logic          addr;
		logic [5:0]    val;
		logic [7:0]    sym;
		logic          has;
		logic          last;
		logic          typed;
		card_verdict_t v;
	} card_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        cfg_we;
	logic        cfg_addr;
	logic [5:0]  cfg_wdata;

	// typed expectation that travels with the item on the input side
	logic          row_typed;
	card_verdict_t row_verdict;

	// predictor copy of the length limits and of the per-string state
	logic [lcc_pkg::CNT_W-1:0] p_min;
	logic [lcc_pkg::CNT_W-1:0] p_max;
	logic                      p_seen;
	logic                      p_bad;
	logic [lcc_pkg::CNT_W-1:0] p_count;
	logic [lcc_pkg::SUM_W-1:0] p_sum_even;
	logic [lcc_pkg::SUM_W-1:0] p_sum_odd;

	card_verdict_t verdict_q[$];
	card_verdict_t got_w;
	card_row_t     directed_rows[$];
	card_row_t     number_rows[$];

	int bad_count;
	int idle_pct;
	int stall_pct;
	int chars_sent;

	luhn_card_number_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// generous ceiling on the whole run
	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// receiver back-pressure, redrawn every falling edge
	always @(negedge clk) begin
		m_tready = ($urandom_range(99, 0) >= stall_pct);
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t ns: %s got %0d want %0d", $time, what, got, want);
		bad_count++;
	endtask

	// fold one accepted item into the predicted string state, queue a verdict on last
	function automatic void luhn_predict(input logic [7:0] sym, input logic has,
			input logic last, input logic typed, input card_verdict_t typed_v);
		int d;
		int dd;
		logic [lcc_pkg::SUM_W-1:0] pick;
		card_verdict_t v;
		if (has) begin
			p_seen = 1'b1;
			if (sym >= lcc_pkg::CH_ZERO && sym <= lcc_pkg::CH_NINE) begin
				// a saturated count freezes both sums too
				if (p_count != lcc_pkg::CNT_MAX) begin
					d = int'(sym) - int'(lcc_pkg::CH_ZERO);
					dd = (d > 4) ? d * 2 - 9 : d * 2;
					if (p_count[0] == 1'b0) begin
						p_sum_even = lcc_pkg::SUM_W'((int'(p_sum_even) + dd) % 10);
						p_sum_odd  = lcc_pkg::SUM_W'((int'(p_sum_odd) + d) % 10);
					end else begin
						p_sum_even = lcc_pkg::SUM_W'((int'(p_sum_even) + d) % 10);
						p_sum_odd  = lcc_pkg::SUM_W'((int'(p_sum_odd) + dd) % 10);
					end
					p_count = p_count + 1'b1;
				end
			end else if (sym != lcc_pkg::CH_SPACE && sym != lcc_pkg::CH_DASH) begin
				p_bad = 1'b1;
			end
		end
		if (last) begin
			// rightmost digit is never doubled, so the parity of the count picks the sum
			pick = p_count[0] ? p_sum_odd : p_sum_even;
			if (!p_seen)
				v.status = lcc_pkg::ST_EMPTY;
			else if (p_bad)
				v.status = lcc_pkg::ST_BADCHAR;
			else if (p_count < p_min || p_count > p_max)
				v.status = lcc_pkg::ST_BADLEN;
			else if (pick != '0)
				v.status = lcc_pkg::ST_LUHN;
			else
				v.status = lcc_pkg::ST_OK;
			v.ok = (v.status == lcc_pkg::ST_OK);
			v.count = p_count;
			verdict_q.push_back(typed ? typed_v : v);
			p_seen = 1'b0;
			p_bad = 1'b0;
			p_count = '0;
			p_sum_even = '0;
			p_sum_odd = '0;
		end
	endfunction

	// input acceptance feeds the predictor, output acceptance is checked in order
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				luhn_predict(s_tdata, s_tuser, s_tlast, row_typed, row_verdict);
			if (m_tvalid && m_tready) begin
				if (verdict_q.size() == 0) begin
					report_mismatch("result item with none pending", int'(m_tdata), 0);
				end else begin
					got_w = verdict_q.pop_front();
					if (m_tdata[0] !== got_w.ok)
						report_mismatch("valid_res", int'(m_tdata[0]), int'(got_w.ok));
					if (m_tdata[3:1] !== got_w.status)
						report_mismatch("status", int'(m_tdata[3:1]), int'(got_w.status));
					if (m_tdata[9:4] !== got_w.count)
						report_mismatch("digit_count", int'(m_tdata[9:4]),
							int'(got_w.count));
					if (m_tdata[15:10] !== 6'd0)
						report_mismatch("pad bits", int'(m_tdata[15:10]), 0);
				end
			end
		end
	end

	function automatic card_row_t row_item(input logic [7:0] sym, input logic has,
			input logic last);
		card_row_t r;
		r.op = ROW_ITEM;
		r.addr = lcc_pkg::REG_MIN_DIGITS;
		r.val = '0;
		r.sym = sym;
		r.has = has;
		r.last = last;
		r.typed = 1'b0;
		r.v = '0;
		return r;
	endfunction

	// string-ending item whose verdict is written out by hand
	function automatic card_row_t row_chk(input logic [7:0] sym, input logic has,
			input logic [lcc_pkg::STAT_W-1:0] st, input logic [lcc_pkg::CNT_W-1:0] cnt);
		card_row_t r;
		r = row_item(sym, has, 1'b1);
		r.typed = 1'b1;
		r.v.ok = (st == lcc_pkg::ST_OK);
		r.v.status = st;
		r.v.count = cnt;
		return r;
	endfunction

	function automatic card_row_t row_cfg(input logic addr, input logic [5:0] val);
		card_row_t r;
		r = row_item(8'h00, 1'b0, 1'b0);
		r.op = ROW_CFG;
		r.addr = addr;
		r.val = val;
		return r;
	endfunction

	// present one item, with sender idling in front of it, and wait until taken
	task automatic send_char(input card_row_t r);
		@(negedge clk);
		while ($urandom_range(99, 0) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata = r.sym;
		s_tuser = r.has;
		s_tlast = r.last;
		row_typed = r.typed;
		row_verdict = r.v;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		if (r.has || r.last)
			chars_sent++;
	endtask

	// block idle: nothing pending, plus the pipeline depth for result-less items
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic addr, input logic [5:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_addr = addr;
		cfg_wdata = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (addr == lcc_pkg::REG_MIN_DIGITS)
			p_min = val;
		else
			p_max = val;
	endtask

	// random card number: mostly well-formed digit runs, some with a forced luhn pass,
	// seasoned with separators, bare items, the odd bad byte and very long runs
	task automatic build_number();
		int n;
		int r;
		int s;
		int lo;
		int hi;
		int bad_at;
		int dig[$];
		card_row_t t;
		number_rows.delete();
		r = $urandom_range(99, 0);
		if (r < 8) begin
			n = $urandom_range(70, 55);
		end else if (r < 20) begin
			n = $urandom_range(6, 0);
		end else begin
			lo = (p_min > 0) ? int'(p_min) - 1 : 0;
			hi = int'(p_max) + 1;
			if (hi > 24)
				hi = 24;
			if (hi < lo)
				hi = lo;
			n = $urandom_range(hi, lo);
		end
		for (int i = 0; i < n; i++)
			dig.push_back($urandom_range(9, 0));
		// fix the check digit, weights counted from the right end
		if (n > 0 && n <= 63 && $urandom_range(1, 0)) begin
			s = 0;
			for (int i = 0; i < n - 1; i++) begin
				if ((n - 1 - i) % 2 == 1)
					s += (dig[i] > 4) ? dig[i] * 2 - 9 : dig[i] * 2;
				else
					s += dig[i];
			end
			dig[n-1] = (10 - s % 10) % 10;
		end
		bad_at = ($urandom_range(99, 0) < 6) ? $urandom_range(n, 0) : -1;
		for (int i = 0; i <= n; i++) begin
			if (i == bad_at)
				number_rows.push_back(row_item(8'($urandom_range(255, 0)), 1'b1, 1'b0));
			if (i < n) begin
				if ($urandom_range(99, 0) < 10)
					number_rows.push_back(row_item(
						$urandom_range(1, 0) ? lcc_pkg::CH_SPACE : lcc_pkg::CH_DASH,
						1'b1, 1'b0));
				if ($urandom_range(99, 0) < 5)
					number_rows.push_back(row_item(8'($urandom_range(255, 0)), 1'b0, 1'b0));
				number_rows.push_back(row_item(8'(int'(lcc_pkg::CH_ZERO) + dig[i]),
					1'b1, 1'b0));
			end
		end
		// end on a bare terminator or on the final character
		if (number_rows.size() == 0 || $urandom_range(99, 0) < 30) begin
			number_rows.push_back(row_item(8'($urandom_range(255, 0)), 1'b0, 1'b1));
		end else begin
			t = number_rows.pop_back();
			t.last = 1'b1;
			number_rows.push_back(t);
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = lcc_pkg::REG_MIN_DIGITS;
		cfg_wdata = '0;
		row_typed = 1'b0;
		row_verdict = '0;
		bad_count = 0;
		idle_pct = 0;
		stall_pct = 0;
		chars_sent = 0;
		p_min = lcc_pkg::MIN_DIGITS_RST;
		p_max = lcc_pkg::MAX_DIGITS_RST;
		p_seen = 1'b0;
		p_bad = 1'b0;
		p_count = '0;
		p_sum_even = '0;
		p_sum_odd = '0;

		// directed table, first rows run with the reset limits 13..19
		directed_rows.push_back(row_chk(8'h00, 1'b0, lcc_pkg::ST_EMPTY, 6'd0));  // bare end
		directed_rows.push_back(row_item(8'hff, 1'b0, 1'b0));         // bare item, no result
		directed_rows.push_back(row_chk(8'hff, 1'b1, lcc_pkg::ST_BADCHAR, 6'd0));  // top byte
		directed_rows.push_back(row_item(8'h00, 1'b1, 1'b0));         // zero byte
		directed_rows.push_back(row_chk("7", 1'b1, lcc_pkg::ST_BADCHAR, 6'd1));  // after bad
		directed_rows.push_back(row_item(lcc_pkg::CH_SPACE, 1'b1, 1'b0));
		// separators only
		directed_rows.push_back(row_chk(lcc_pkg::CH_DASH, 1'b1, lcc_pkg::ST_BADLEN, 6'd0));
		directed_rows.push_back(row_item(":", 1'b1, 1'b0));           // just above nine
		directed_rows.push_back(row_chk("/", 1'b1, lcc_pkg::ST_BADCHAR, 6'd0));  // below zero
		directed_rows.push_back(row_cfg(lcc_pkg::REG_MIN_DIGITS, 6'd1));
		directed_rows.push_back(row_cfg(lcc_pkg::REG_MAX_DIGITS, 6'd2));
		directed_rows.push_back(row_item("1", 1'b1, 1'b0));
		directed_rows.push_back(row_item("8", 1'b1, 1'b1));           // luhn pass
		directed_rows.push_back(row_item("1", 1'b1, 1'b0));
		directed_rows.push_back(row_item("9", 1'b1, 1'b0));
		directed_rows.push_back(row_item(8'h55, 1'b0, 1'b1));         // luhn fail, bare end
		directed_rows.push_back(row_item("0", 1'b1, 1'b1));           // single zero digit
		directed_rows.push_back(row_item("9", 1'b1, 1'b0));
		directed_rows.push_back(row_item(lcc_pkg::CH_DASH, 1'b1, 1'b0));
		directed_rows.push_back(row_item("1", 1'b1, 1'b1));
		directed_rows.push_back(row_item("1", 1'b1, 1'b0));
		directed_rows.push_back(row_item("2", 1'b1, 1'b0));
		directed_rows.push_back(row_chk("3", 1'b1, lcc_pkg::ST_BADLEN, 6'd3));  // one over max
		// crossed bounds: every clean string fails on length
		directed_rows.push_back(row_cfg(lcc_pkg::REG_MIN_DIGITS, 6'd63));
		directed_rows.push_back(row_cfg(lcc_pkg::REG_MAX_DIGITS, 6'd0));
		directed_rows.push_back(row_chk("5", 1'b1, lcc_pkg::ST_BADLEN, 6'd1));

		// single reset at the start, released on a falling edge
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].op == ROW_CFG) begin
				settle();
				write_reg(directed_rows[i].addr, directed_rows[i].val);
			end else begin
				send_char(directed_rows[i]);
			end
		end

		// random phases, each with its own limits and idle pattern
		for (int ph = 0; ph < 7; ph++) begin
			settle();
			case (ph)
				0: begin
					write_reg(lcc_pkg::REG_MIN_DIGITS, lcc_pkg::MIN_DIGITS_RST);
					write_reg(lcc_pkg::REG_MAX_DIGITS, lcc_pkg::MAX_DIGITS_RST);
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					write_reg(lcc_pkg::REG_MIN_DIGITS, 6'd0);
					write_reg(lcc_pkg::REG_MAX_DIGITS, 6'd63);
					idle_pct = 73;
					stall_pct = 0;
				end
				2: begin
					write_reg(lcc_pkg::REG_MIN_DIGITS, 6'd16);
					write_reg(lcc_pkg::REG_MAX_DIGITS, 6'd16);
					idle_pct = 0;
					stall_pct = 73;
				end
				3: begin
					write_reg(lcc_pkg::REG_MIN_DIGITS, 6'($urandom_range(63, 0)));
					write_reg(lcc_pkg::REG_MAX_DIGITS, 6'($urandom_range(63, 0)));
					idle_pct = 38;
					stall_pct = 38;
				end
				4: begin
					write_reg(lcc_pkg::REG_MIN_DIGITS, 6'd20);
					write_reg(lcc_pkg::REG_MAX_DIGITS, 6'd5);
					idle_pct = 73;
					stall_pct = 0;
				end
				5: begin
					write_reg(lcc_pkg::REG_MIN_DIGITS, 6'd63);
					write_reg(lcc_pkg::REG_MAX_DIGITS, 6'd63);
					idle_pct = 0;
					stall_pct = 73;
				end
				default: begin
					write_reg(lcc_pkg::REG_MIN_DIGITS, 6'($urandom_range(20, 0)));
					write_reg(lcc_pkg::REG_MAX_DIGITS, 6'($urandom_range(63, 10)));
					idle_pct = 38;
					stall_pct = 38;
				end
			endcase
			chars_sent = 0;
			while (chars_sent < 115) begin
				build_number();
				foreach (number_rows[i])
					send_char(number_rows[i]);
			end
		end

		// drain everything still in flight, then judge
		settle();
		repeat (8) @(posedge clk);
		if (bad_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
